// ----- design/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; used by every module of the block.
package pps_pkg;

  localparam int DEF_MAX_PROCS = 16;

  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRI_W   = 8;
  localparam int TIME_W  = 32;
  localparam int PID_W   = 4;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 104;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [PRI_W-1:0]   priority_lvl;
  } proc_entry_t;

  typedef struct packed {
    logic        found;
    proc_entry_t entry;
  } best_t;

endpackage

// ----- design/pps_proc_ram.sv -----
// Process table storage: one write port, one registered read port.
// Depends on pps_pkg for the entry type.
module pps_proc_ram
  import pps_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_PROCS,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  proc_entry_t       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output proc_entry_t       rdata
);

  proc_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/pps_select.sv -----
// Running best-candidate tracker fed by the table scan, one entry per cycle.
// Depends on pps_pkg for entry and result types.
module pps_select
  import pps_pkg::*;
#(
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic [TIME_W-1:0] cur_time,
  input  logic              rd_vld,
  input  logic [ADDR_W-1:0] rd_idx,
  input  proc_entry_t       rd_data,
  output best_t             best,
  output logic [ADDR_W-1:0] best_idx
);

  logic              found_r;
  proc_entry_t       entry_r;
  logic [ADDR_W-1:0] idx_r;
  logic              take;

  assign take = rd_vld
             && ({{(TIME_W-ARR_W){1'b0}}, rd_data.arrival} <= cur_time)
             && (rd_data.remaining != '0)
             && (!found_r || (rd_data.priority_lvl < entry_r.priority_lvl));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !clear) begin
      entry_r <= rd_data;
      idx_r   <= rd_idx;
    end
  end

  assign best.found = found_r;
  assign best.entry = entry_r;
  assign best_idx   = idx_r;

endmodule

// ----- design/preemptive_priority_scheduler.sv -----
// A load transaction passes through the accepting state, a table write state and a report
// state. A tick transaction passes through the accepting state, a scan of the process table
// RAM (registered read port) at one slot per cycle, a drain state for the read latency, a
// read-modify-write state and a report state; an empty table skips the scan and the drain
// state. One transaction is worked on at a time; a finished result sits in the output
// register, so the next transaction is accepted while it waits, and its report state
// stretches until that register is free.
// Depends on pps_pkg, pps_proc_ram and pps_select.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = DEF_MAX_PROCS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] arrival_time, [31:16] burst_time, [39:32] priority_req
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] load_accepted, [4:1] process_id, [5] ran, [6] finished,
  // [38:7] completion_time, [70:39] turnaround, [102:71] waiting, [103] all_done
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int ADDR_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int EXT_W  = (CNT_W > PID_W) ? CNT_W : PID_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      loaded_count_r, loaded_count_nxt;
  logic [CNT_W-1:0]      finished_count_r, finished_count_nxt;
  logic [TIME_W-1:0]     cur_time_r, cur_time_nxt;
  logic [CNT_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]     rd_idx_r;

  logic [ARR_W-1:0]      req_arrival_r;
  logic [BURST_W-1:0]    req_burst_r;
  logic [PRI_W-1:0]      req_pri_r;

  logic                  res_acc_r, res_acc_nxt;
  logic [PID_W-1:0]      res_pid_r, res_pid_nxt;
  logic                  res_ran_r, res_ran_nxt;
  logic                  res_fin_r, res_fin_nxt;
  logic [TIME_W-1:0]     res_ct_r, res_ct_nxt;
  logic [TIME_W-1:0]     res_tat_r, res_tat_nxt;
  logic [BURST_W-1:0]    res_burst_r, res_burst_nxt;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  emit;
  logic                  sel_clear;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  proc_entry_t           ram_wdata;
  logic                  ram_re;
  proc_entry_t           ram_rdata;

  best_t                 best;
  logic [ADDR_W-1:0]     best_idx;
  logic [EXT_W-1:0]      slot_ext;
  logic [EXT_W-1:0]      best_ext;
  logic [BURST_W-1:0]    rem_dec;
  logic [TIME_W-1:0]     tat_calc;
  logic [TIME_W-1:0]     wt_calc;
  logic [TIME_W-1:0]     burst_ext;
  logic                  all_done;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign emit      = (state_r == ST_EMIT) && out_free;
  assign sel_clear = in_acc && (in_tuser == KIND_TICK);

  assign slot_ext  = EXT_W'(loaded_count_r);
  assign best_ext  = EXT_W'(best_idx);
  assign rem_dec   = best.entry.remaining - BURST_W'(1);
  assign tat_calc  = cur_time_nxt - {{(TIME_W-ARR_W){1'b0}}, best.entry.arrival};
  assign burst_ext = {{(TIME_W-BURST_W){1'b0}}, res_burst_r};
  assign wt_calc   = (res_fin_r && (res_tat_r >= burst_ext)) ? (res_tat_r - burst_ext) : '0;
  assign all_done  = (finished_count_r == loaded_count_r);

  pps_proc_ram #(
    .DEPTH  (MAX_PROCS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  pps_select #(
    .ADDR_W (ADDR_W)
  ) u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (sel_clear),
    .cur_time (cur_time_r),
    .rd_vld   (rd_vld_r),
    .rd_idx   (rd_idx_r),
    .rd_data  (ram_rdata),
    .best     (best),
    .best_idx (best_idx)
  );

  always_comb begin
    state_nxt          = state_r;
    loaded_count_nxt   = loaded_count_r;
    finished_count_nxt = finished_count_r;
    cur_time_nxt       = cur_time_r;
    scan_idx_nxt       = scan_idx_r;
    rd_vld_nxt         = 1'b0;
    res_acc_nxt        = res_acc_r;
    res_pid_nxt        = res_pid_r;
    res_ran_nxt        = res_ran_r;
    res_fin_nxt        = res_fin_r;
    res_ct_nxt         = res_ct_r;
    res_tat_nxt        = res_tat_r;
    res_burst_nxt      = res_burst_r;
    ram_we             = 1'b0;
    ram_waddr          = loaded_count_r[ADDR_W-1:0];
    ram_wdata          = '{arrival: req_arrival_r, burst: req_burst_r,
                           remaining: req_burst_r, priority_lvl: req_pri_r};
    ram_re             = 1'b0;
    if (cur_time_r != '1) begin
      cur_time_nxt = cur_time_r + TIME_W'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        cur_time_nxt = cur_time_r;
        if (in_acc) begin
          scan_idx_nxt = '0;
          if (in_tuser == KIND_LOAD) begin
            state_nxt = ST_LOAD;
          end else if (loaded_count_r == '0) begin
            state_nxt = ST_UPD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        cur_time_nxt = cur_time_r;
        res_ran_nxt  = 1'b0;
        res_fin_nxt  = 1'b0;
        res_ct_nxt   = '0;
        res_tat_nxt  = '0;
        if ((loaded_count_r < CNT_W'(MAX_PROCS)) && (req_burst_r != '0)) begin
          ram_we           = 1'b1;
          loaded_count_nxt = loaded_count_r + CNT_W'(1);
          res_acc_nxt      = 1'b1;
          res_pid_nxt      = slot_ext[PID_W-1:0];
        end else begin
          res_acc_nxt = 1'b0;
          res_pid_nxt = '0;
        end
        state_nxt = ST_EMIT;
      end
      ST_SCAN: begin
        cur_time_nxt = cur_time_r;
        ram_re       = 1'b1;
        rd_vld_nxt   = 1'b1;
        scan_idx_nxt = scan_idx_r + CNT_W'(1);
        if (scan_idx_r == loaded_count_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cur_time_nxt = cur_time_r;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        res_acc_nxt   = 1'b0;
        res_burst_nxt = best.entry.burst;
        ram_waddr     = best_idx;
        ram_wdata     = best.entry;
        ram_wdata.remaining = rem_dec;
        if (best.found) begin
          ram_we      = 1'b1;
          res_pid_nxt = best_ext[PID_W-1:0];
          res_ran_nxt = 1'b1;
          if (rem_dec == '0) begin
            res_fin_nxt        = 1'b1;
            finished_count_nxt = finished_count_r + CNT_W'(1);
            res_ct_nxt         = cur_time_nxt;
            res_tat_nxt        = tat_calc;
          end else begin
            res_fin_nxt = 1'b0;
            res_ct_nxt  = '0;
            res_tat_nxt = '0;
          end
        end else begin
          res_pid_nxt = '0;
          res_ran_nxt = 1'b0;
          res_fin_nxt = 1'b0;
          res_ct_nxt  = '0;
          res_tat_nxt = '0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cur_time_nxt = cur_time_r;
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        cur_time_nxt = cur_time_r;
        state_nxt    = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      loaded_count_r   <= '0;
      finished_count_r <= '0;
      cur_time_r       <= '0;
      scan_idx_r       <= '0;
      rd_vld_r         <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      loaded_count_r   <= loaded_count_nxt;
      finished_count_r <= finished_count_nxt;
      cur_time_r       <= cur_time_nxt;
      scan_idx_r       <= scan_idx_nxt;
      rd_vld_r         <= rd_vld_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= scan_idx_r[ADDR_W-1:0];
    res_acc_r   <= res_acc_nxt;
    res_pid_r   <= res_pid_nxt;
    res_ran_r   <= res_ran_nxt;
    res_fin_r   <= res_fin_nxt;
    res_ct_r    <= res_ct_nxt;
    res_tat_r   <= res_tat_nxt;
    res_burst_r <= res_burst_nxt;
    if (in_acc) begin
      req_arrival_r <= in_tdata[15:0];
      req_burst_r   <= in_tdata[31:16];
      req_pri_r     <= in_tdata[39:32];
    end
    if (emit) begin
      out_data_r <= {all_done, wt_calc, res_tat_r, res_ct_r,
                     res_fin_r, res_ran_r, res_pid_r, res_acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
